[design/gdd_pkg.sv]
// shared types, widths and calendar tables for the gregorian date difference unit
package gdd_pkg;

  // field widths
  localparam int unsigned YEAR_BITS  = 14;
  localparam int unsigned DAY_BITS   = 6;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned DIFF_BITS  = 23;

  // day-of-year fits 1..366
  localparam int unsigned DOY_BITS = 9;
  // day number up to about 366 * 2^YEAR_BITS
  localparam int unsigned NUM_BITS = YEAR_BITS + 9;
  // width that holds both a day number and the saturation limit
  localparam int unsigned WIDE_BITS = (NUM_BITS > DIFF_BITS) ? NUM_BITS : DIFF_BITS;

  // exact floor division by 100 through a reciprocal multiply
  localparam int unsigned DIV100_SHIFT = YEAR_BITS + 7;
  localparam int unsigned MAGIC_BITS   = YEAR_BITS + 1;
  localparam int unsigned Q_BITS       = YEAR_BITS - 6;
  localparam int unsigned PROD_BITS    = YEAR_BITS + MAGIC_BITS;
  localparam logic [MAGIC_BITS-1:0] DIV100_MAGIC =
    MAGIC_BITS'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

  localparam logic [DIFF_BITS-1:0] DIFF_MAX = '1;

  localparam logic [MONTH_BITS-1:0] MONTH_FIRST = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] MONTH_LAST  = MONTH_BITS'(12);

  // input transaction
  typedef struct packed {
    logic [DAY_BITS-1:0]   first_day;
    logic [MONTH_BITS-1:0] first_month;
    logic [YEAR_BITS-1:0]  first_year;
    logic [DAY_BITS-1:0]   second_day;
    logic [MONTH_BITS-1:0] second_month;
    logic [YEAR_BITS-1:0]  second_year;
  } gdd_in_t;

  // result transaction
  typedef struct packed {
    logic                 invalid_date;
    logic [DIFF_BITS-1:0] day_difference;
  } gdd_out_t;

  // length of a month, february follows the leap flag
  function automatic logic [4:0] month_len(input logic [MONTH_BITS-1:0] m,
                                           input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of a month
  function automatic logic [DOY_BITS-1:0] days_before(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
    logic [DOY_BITS-1:0] base;
    unique case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[design/gregorian_date_difference_unit.sv]
// top level: five-stage pipeline computing the day count between two dates
//
// Usage:
//   One input transaction on in_valid/in_stall/in_data carries two calendar
//   dates. Each transaction yields exactly one result transaction on
//   out_valid/out_stall/out_data: invalid_date set (and a zero difference)
//   when either date has a bad month, a zero day, a day past the month end
//   or a zero year; otherwise the absolute day count between the dates,
//   saturated at the 23-bit limit.
//   Path: an accepted input passes the five register stages (divide-by-100
//   multiply, calendar tables, day-number sum, subtract, saturate) and its
//   result shows on out_valid from the output register. Throughput: one
//   transaction per cycle while out_stall is low, each stage taking a new item.
//   Stalls: out_stall holds the output register; a stage only waits when the
//   stage after it is full and waiting, so bubbles close up and in_stall
//   rises only once the pipeline behind the stalled result is full.
//   Reset: synchronous, active-low rst_n empties every stage; no transaction
//   is held across reset.
module gregorian_date_difference_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gdd_pkg::gdd_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gdd_pkg::gdd_out_t out_data
);

  localparam int unsigned YB   = gdd_pkg::YEAR_BITS;
  localparam int unsigned DB   = gdd_pkg::DAY_BITS;
  localparam int unsigned MB   = gdd_pkg::MONTH_BITS;
  localparam int unsigned QB   = gdd_pkg::Q_BITS;
  localparam int unsigned NB   = gdd_pkg::NUM_BITS;
  localparam int unsigned WB   = gdd_pkg::WIDE_BITS;
  localparam int unsigned PB   = gdd_pkg::PROD_BITS;
  localparam int unsigned OB   = gdd_pkg::DOY_BITS;

  typedef struct packed {
    logic [YB-1:0] p;
    logic [QB-1:0] q;
    logic [DB-1:0] day;
    logic [MB-1:0] month;
    logic          ok;
  } s1_t;

  typedef struct packed {
    logic [YB-1:0] p;
    logic [QB-1:0] q;
    logic [OB-1:0] doy;
    logic          ok;
  } s2_t;

  typedef struct packed {
    logic [NB-1:0] num;
    logic          ok;
  } s3_t;

  typedef struct packed {
    logic [NB-1:0] diff;
    logic          ok;
  } s4_t;

  // stage registers
  s1_t s1_r [2];
  s1_t s1_nxt [2];
  s2_t s2_r [2];
  s2_t s2_nxt [2];
  s3_t s3_r [2];
  s3_t s3_nxt [2];
  s4_t s4_r;
  s4_t s4_nxt;
  gdd_pkg::gdd_out_t out_r;
  gdd_pkg::gdd_out_t out_nxt;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic adv1, adv2, adv3, adv4, adv_out;

  // per-date views of the input transaction
  logic [YB-1:0] yr_in  [2];
  logic [DB-1:0] day_in [2];
  logic [MB-1:0] mon_in [2];
  logic [YB-1:0] p_in   [2];
  logic [PB-1:0] prod   [2];

  logic [YB-1:0] rem    [2];
  logic          cent   [2];
  logic          leap   [2];
  logic [4:0]    lim    [2];

  logic [WB-1:0] diff_wide;

  // stage advance: a stage moves when it is empty or its successor moves
  assign adv_out  = !out_vld_r || !out_stall;
  assign adv4     = !s4_vld_r || adv_out;
  assign adv3     = !s3_vld_r || adv4;
  assign adv2     = !s2_vld_r || adv3;
  assign adv1     = !s1_vld_r || adv2;
  assign in_stall = !adv1;

  // split the transaction into two dates
  always_comb begin
    yr_in[0]  = in_data.first_year;
    day_in[0] = in_data.first_day;
    mon_in[0] = in_data.first_month;
    yr_in[1]  = in_data.second_year;
    day_in[1] = in_data.second_day;
    mon_in[1] = in_data.second_month;
  end

  // stage 1: range checks, previous year, divide by 100 via reciprocal
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      p_in[i]         = yr_in[i] - YB'(1);
      prod[i]         = PB'(p_in[i]) * PB'(gdd_pkg::DIV100_MAGIC);
      s1_nxt[i].p     = p_in[i];
      s1_nxt[i].q     = prod[i][gdd_pkg::DIV100_SHIFT +: QB];
      s1_nxt[i].day   = day_in[i];
      s1_nxt[i].month = mon_in[i];
      s1_nxt[i].ok    = (mon_in[i] >= gdd_pkg::MONTH_FIRST) &&
                        (mon_in[i] <= gdd_pkg::MONTH_LAST) &&
                        (day_in[i] != '0) && (yr_in[i] != '0);
    end
  end

  // stage 2: leap rule, month length check, day of year
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem[i]  = s1_r[i].p - YB'(s1_r[i].q) * YB'(100);
      // year is a century when the previous year ends in 99
      cent[i] = (rem[i] == YB'(99));
      leap[i] = ((s1_r[i].p[1:0] == 2'b11) && !cent[i]) ||
                (cent[i] && (s1_r[i].q[1:0] == 2'b11));
      lim[i]  = gdd_pkg::month_len(s1_r[i].month, leap[i]);
      s2_nxt[i].p   = s1_r[i].p;
      s2_nxt[i].q   = s1_r[i].q;
      s2_nxt[i].doy = gdd_pkg::days_before(s1_r[i].month, leap[i]) + OB'(s1_r[i].day);
      s2_nxt[i].ok  = s1_r[i].ok && (s1_r[i].day <= DB'(lim[i]));
    end
  end

  // stage 3: day number counted from 1 january of year 1
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_nxt[i].num = NB'(s2_r[i].p) * NB'(365) + NB'(s2_r[i].p >> 2)
                      - NB'(s2_r[i].q) + NB'(s2_r[i].q >> 2) + NB'(s2_r[i].doy);
      s3_nxt[i].ok  = s2_r[i].ok;
    end
  end

  // stage 4: absolute difference
  always_comb begin
    s4_nxt.diff = (s3_r[0].num >= s3_r[1].num) ? (s3_r[0].num - s3_r[1].num)
                                                 : (s3_r[1].num - s3_r[0].num);
    s4_nxt.ok   = s3_r[0].ok && s3_r[1].ok;
  end

  // output stage: saturate and zero on error
  always_comb begin
    diff_wide            = WB'(s4_r.diff);
    out_nxt.invalid_date = !s4_r.ok;
    if (!s4_r.ok) begin
      out_nxt.day_difference = '0;
    end else if (diff_wide > WB'(gdd_pkg::DIFF_MAX)) begin
      out_nxt.day_difference = gdd_pkg::DIFF_MAX;
    end else begin
      out_nxt.day_difference = gdd_pkg::DIFF_BITS'(diff_wide);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_r <= in_valid;
      end
      if (adv2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (adv3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (adv4) begin
        s4_vld_r <= s3_vld_r;
      end
      if (adv_out) begin
        out_vld_r <= s4_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (adv2 && s1_vld_r) begin
      s2_r <= s2_nxt;
    end
    if (adv3 && s2_vld_r) begin
      s3_r <= s3_nxt;
    end
    if (adv4 && s3_vld_r) begin
      s4_r <= s4_nxt;
    end
    if (adv_out && s4_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[design/gdd_checker.sv]
// port-level checker for the gregorian date difference unit, with its bind
module gdd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input gdd_pkg::gdd_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input gdd_pkg::gdd_out_t out_data
);

  // a stalled input transaction stays and holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  // a stalled result transaction stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // an error result carries a zero day count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid_date |-> out_data.day_difference == '0)
    else $error("invalid date with nonzero difference");

  // input back-pressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

endmodule

bind gregorian_date_difference_unit gdd_checker u_gdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/tb_gregorian_date_difference_unit.sv]
// self-checking testbench for the gregorian date difference unit
module tb_gregorian_date_difference_unit;

  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned CALM_ITEMS   = 300;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned YEAR_TOP     = (1 << gdd_pkg::YEAR_BITS) - 1;

  typedef struct packed {
    logic [gdd_pkg::DAY_BITS-1:0]   day;
    logic [gdd_pkg::MONTH_BITS-1:0] month;
    logic [gdd_pkg::YEAR_BITS-1:0]  year;
  } date_t;

  localparam int unsigned DATE_BITS = $bits(date_t);

  // expected day counts in acceptance order, checked against the result channel
  class day_count_board;
    gdd_pkg::gdd_out_t expected_q[$];
    int unsigned       errors;
    int unsigned       month_days[12];

    function new();
      month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      errors = 0;
    endfunction

    // days since 1 january of year 1 (that day is 1), zero return for a bad date
    function bit day_number(input logic [gdd_pkg::DAY_BITS-1:0] d,
                            input logic [gdd_pkg::MONTH_BITS-1:0] m,
                            input logic [gdd_pkg::YEAR_BITS-1:0] y,
                            output longint unsigned num);
      bit leap;
      int unsigned lim;
      longint unsigned days_ahead;
      longint unsigned p;
      num = 0;
      if (m < 1 || m > 12 || d == 0 || y == 0) begin
        return 1'b0;
      end
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      lim = month_days[m - 1];
      if (m == 2 && leap) begin
        lim = 29;
      end
      if (d > lim) begin
        return 1'b0;
      end
      days_ahead = 0;
      for (int i = 0; i + 1 < m; i++) begin
        days_ahead += month_days[i];
      end
      if (leap && m > 2) begin
        days_ahead += 1;
      end
      p = y;
      p = p - 1;
      num = p * 365 + p / 4 - p / 100 + p / 400 + days_ahead + d;
      return 1'b1;
    endfunction

    function gdd_pkg::gdd_out_t predict_difference(input gdd_pkg::gdd_in_t item);
      gdd_pkg::gdd_out_t res;
      longint unsigned n1;
      longint unsigned n2;
      longint unsigned span;
      bit ok1;
      bit ok2;
      res = '0;
      ok1 = day_number(item.first_day, item.first_month, item.first_year, n1);
      ok2 = day_number(item.second_day, item.second_month, item.second_year, n2);
      if (!ok1 || !ok2) begin
        res.invalid_date = 1'b1;
      end else begin
        span = (n1 > n2) ? (n1 - n2) : (n2 - n1);
        if (span > gdd_pkg::DIFF_MAX) begin
          span = 64'(gdd_pkg::DIFF_MAX);
        end
        res.day_difference = span[gdd_pkg::DIFF_BITS-1:0];
      end
      return res;
    endfunction

    function void note(input gdd_pkg::gdd_in_t item);
      expected_q.push_back(predict_difference(item));
    endfunction

    function void check(input gdd_pkg::gdd_out_t got);
      gdd_pkg::gdd_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: expected none, got invalid_date %0b %s %0d",
                 $time, got.invalid_date, "day_difference", got.day_difference);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.invalid_date !== want.invalid_date) begin
        $display("%0t: invalid_date mismatch: expected %0b, got %0b",
                 $time, want.invalid_date, got.invalid_date);
        errors++;
      end
      if (got.day_difference !== want.day_difference) begin
        $display("%0t: day_difference mismatch: expected %0d, got %0d",
                 $time, want.day_difference, got.day_difference);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  gdd_pkg::gdd_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  gdd_pkg::gdd_out_t out_data;

  bit             calm;
  bit             hold_pending;
  int unsigned    cycle_count;
  day_count_board board;

  gregorian_date_difference_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note(in_data);
      end
      if (out_valid && !out_stall) begin
        board.check(out_data);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none once calm
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m == 2) begin
      return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    end
    if (m inside {4, 6, 9, 11}) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic date_t on_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t dt;
    dt.day   = gdd_pkg::DAY_BITS'(d);
    dt.month = gdd_pkg::MONTH_BITS'(m);
    dt.year  = gdd_pkg::YEAR_BITS'(y);
    return dt;
  endfunction

  // valid date within the given year
  function automatic date_t pick_date(input int unsigned y);
    int unsigned m;
    m = $urandom_range(1, 12);
    return on_date($urandom_range(1, month_length(m, y)), m, y);
  endfunction

  // break one field of a valid date
  function automatic date_t spoil_date(input date_t a);
    date_t bad;
    bad = a;
    case ($urandom_range(0, 3))
      0: bad.month = $urandom_range(0, 1) ? gdd_pkg::MONTH_BITS'(0)
                                          : gdd_pkg::MONTH_BITS'($urandom_range(13, 15));
      1: bad.day = '0;
      2: bad.day = gdd_pkg::DAY_BITS'($urandom_range(
                     month_length(32'(a.month), 32'(a.year)) + 1, 63));
      default: bad.year = '0;
    endcase
    return bad;
  endfunction

  function automatic gdd_pkg::gdd_in_t pair(input date_t a, input date_t b);
    gdd_pkg::gdd_in_t item;
    item.first_day    = a.day;
    item.first_month  = a.month;
    item.first_year   = a.year;
    item.second_day   = b.day;
    item.second_month = b.month;
    item.second_year  = b.year;
    return item;
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_item(input gdd_pkg::gdd_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_item(input gdd_pkg::gdd_in_t item);
    send_item(item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stimulus and end of run
  initial begin
    date_t a;
    date_t b;
    int unsigned kind;
    board = new();
    calm = 1'b0;
    hold_pending = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range ends, leap rules, bad fields, order of dates
    run_item(pair(on_date(1, 1, 1), on_date(31, 12, YEAR_TOP)));
    run_item(pair(on_date(31, 12, YEAR_TOP), on_date(1, 1, 1)));
    run_item(pair(on_date(15, 6, 2000), on_date(15, 6, 2000)));
    run_item(pair(on_date(29, 2, 2000), on_date(1, 3, 2000)));
    run_item(pair(on_date(29, 2, 1900), on_date(1, 3, 1900)));
    run_item(pair(on_date(29, 2, 2024), on_date(28, 2, 2023)));
    run_item(pair(on_date(29, 2, 2023), on_date(1, 1, 2023)));
    run_item(pair(on_date(31, 4, 2020), on_date(1, 5, 2020)));
    run_item(pair(on_date(30, 4, 2020), on_date(1, 5, 2020)));
    run_item(pair(on_date(10, 0, 2020), on_date(1, 5, 2020)));
    run_item(pair(on_date(1, 5, 2020), on_date(10, 13, 2020)));
    run_item(pair(on_date(10, 15, 2020), on_date(1, 5, 2020)));
    run_item(pair(on_date(0, 7, 1984), on_date(1, 7, 1984)));
    run_item(pair(on_date(1, 7, 1984), on_date(63, 7, 1984)));
    run_item(pair(on_date(1, 1, 0), on_date(1, 1, 1)));
    run_item(pair(on_date(1, 1, 1), on_date(1, 1, 0)));
    run_item(pair(on_date(10, 3, 1999), on_date(5, 3, 2005)));
    run_item(pair(on_date(5, 3, 1999), on_date(10, 3, 2005)));
    run_item(pair(on_date(31, 12, 1999), on_date(1, 1, 2000)));
    run_item(pair(on_date(63, 15, YEAR_TOP), on_date(63, 15, YEAR_TOP)));
    run_item(pair(on_date(0, 0, 0), on_date(0, 0, 0)));
    run_item(pair(on_date(31, 12, YEAR_TOP), on_date(1, 1, YEAR_TOP)));

    // random: mostly valid pairs, some broken dates and raw noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        hold_pending = 1'b1;
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      kind = $urandom_range(0, 99);
      a = pick_date($urandom_range(1, YEAR_TOP));
      if (kind < 5) begin
        b = a;
      end else if (kind < 55) begin
        b = pick_date($urandom_range(1, YEAR_TOP));
      end else if (kind < 70) begin
        // same month in another year
        b = a;
        b.year = gdd_pkg::YEAR_BITS'($urandom_range(1, YEAR_TOP));
        b.day  = gdd_pkg::DAY_BITS'($urandom_range(1,
                   month_length(32'(b.month), 32'(b.year))));
      end else if (kind < 78) begin
        b = pick_date(32'(a.year));
      end else if (kind < 90) begin
        b = pick_date($urandom_range(1, YEAR_TOP));
        if ($urandom_range(0, 1)) begin
          a = spoil_date(a);
        end else begin
          b = spoil_date(b);
        end
      end else begin
        a = date_t'(DATE_BITS'($urandom));
        b = date_t'(DATE_BITS'($urandom));
      end
      run_item(pair(a, b));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // drain and report
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
